FILE: design/pshb_pkg.sv
// ---------------------------------------------------------------------------
// pshb_pkg
// shared types and constants for the point slice height binning block
// ---------------------------------------------------------------------------
`default_nettype none

package pshb_pkg;

  // command queue between classifier and store engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int CNT_W       = 3;

  // row and column index width carried in a command (largest grid side)
  localparam int IDX_W = 10;

  // rounding of (coord - centre) * scale / 2^18
  localparam int ROUND_SHIFT = 18;

  localparam logic signed [23:0] H_MIN = 24'sh800000;
  localparam logic signed [23:0] H_MAX = 24'sh7fffff;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CELL_SCALE  = 3'd2,
    REG_SLICE_BASE  = 3'd3,
    REG_SLICE_STEP  = 3'd4,
    REG_SLICE_COUNT = 3'd5,
    REG_ROWS_USED   = 3'd6,
    REG_COLS_USED   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [2:0]         cell_slice;
    logic [6:0]         cell_row;
    logic [6:0]         cell_col;
  } req_item_t;

  typedef struct packed {
    logic               in_grid;
    logic signed [23:0] ground_height;
    logic signed [23:0] ceiling_height;
  } rsp_item_t;

  // configuration as seen by the datapath, with clamped sizes
  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [15:0]        cell_scale;
    logic signed [23:0] slice_base;
    logic [22:0]        slice_step;
    logic [3:0]         ns;
    logic [7:0]         nr;
    logic [7:0]         nc;
  } cfg_t;

  typedef struct packed {
    req_kind_t          op;
    logic               hit;
    logic [2:0]         slice;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [23:0] pz;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/pshb_front.sv
// ---------------------------------------------------------------------------
// pshb_front
// classifier: maps points to grid cells, checks addresses, queues commands
// ---------------------------------------------------------------------------
`default_nettype none

module pshb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  pshb_pkg::req_item_t         req_item,
  input  pshb_pkg::cfg_t              cfg,
  input  logic                        init_busy,
  input  logic [pshb_pkg::CNT_W-1:0]  q_count,
  output logic                        push,
  output pshb_pkg::cmd_t              push_cmd
);
  import pshb_pkg::*;

  logic                 accept;
  logic [CNT_W:0]       occ;
  logic signed [16:0]   scale_s;

  logic                 a_valid, b_valid, c_valid;
  req_item_t            a_item, b_item, c_item;
  logic signed [24:0]   a_dx, a_dy;
  logic signed [41:0]   b_px, b_py;
  logic signed [23:0]   c_qx, c_qy;

  logic [25:0]          row_s, col_s;
  logic                 x_in, y_in, rc_ok;
  req_kind_t            op;

  // round half away from zero, arithmetic shift floors
  function automatic logic signed [23:0] round_cells(input logic signed [41:0] p);
    logic signed [41:0] s;
    s = p + (p[41] ? 42'sd131071 : 42'sd131072);
    return s[41:ROUND_SHIFT];
  endfunction

  // space is reserved for every transaction in flight
  assign occ = (CNT_W+1)'(q_count) + (CNT_W+1)'(a_valid) + (CNT_W+1)'(b_valid)
             + (CNT_W+1)'(c_valid);
  assign req_ready = !init_busy && (occ < (CNT_W+1)'(QUEUE_DEPTH));
  assign accept    = req_valid && req_ready;
  assign scale_s   = $signed({1'b0, cfg.cell_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_item <= req_item;
    a_dx   <= 25'(req_item.point_x) - 25'(cfg.center_x);
    a_dy   <= 25'(req_item.point_y) - 25'(cfg.center_y);
    b_item <= a_item;
    b_px   <= a_dx * scale_s;
    b_py   <= a_dy * scale_s;
    c_item <= b_item;
    c_qx   <= round_cells(b_px);
    c_qy   <= round_cells(b_py);
  end

  always_comb begin
    row_s = 26'(c_qx) + 26'(cfg.nr[7:1]);
    col_s = 26'(c_qy) + 26'(cfg.nc[7:1]);
    x_in  = !row_s[25] && (row_s[24:0] < 25'(cfg.nr));
    y_in  = !col_s[25] && (col_s[24:0] < 25'(cfg.nc));
    rc_ok = ({1'b0, c_item.cell_slice} < cfg.ns) && ({1'b0, c_item.cell_row} < cfg.nr)
         && ({1'b0, c_item.cell_col} < cfg.nc);
    op    = req_kind_t'(c_item.req_type);

    push_cmd.op    = op;
    push_cmd.slice = c_item.cell_slice;
    push_cmd.pz    = c_item.point_z;
    case (op)
      REQ_INSERT: begin
        push_cmd.hit = x_in && y_in;
        push_cmd.row = row_s[IDX_W-1:0];
        push_cmd.col = col_s[IDX_W-1:0];
      end
      REQ_READ, REQ_CLEAR: begin
        push_cmd.hit = rc_ok;
        push_cmd.row = IDX_W'(c_item.cell_row);
        push_cmd.col = IDX_W'(c_item.cell_col);
      end
      default: begin
        push_cmd.hit = 1'b0;
        push_cmd.row = IDX_W'(c_item.cell_row);
        push_cmd.col = IDX_W'(c_item.cell_col);
      end
    endcase
  end

  assign push = c_valid;

endmodule

`default_nettype wire

FILE: design/pshb_queue.sv
// ---------------------------------------------------------------------------
// pshb_queue
// short command queue between classifier and store engine
// ---------------------------------------------------------------------------
`default_nettype none

module pshb_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  pshb_pkg::cmd_t              push_cmd,
  input  logic                        pop,
  output pshb_pkg::cmd_t              head,
  output logic                        empty,
  output logic [pshb_pkg::CNT_W-1:0]  count
);
  import pshb_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

endmodule

`default_nettype wire

FILE: design/pshb_back.sv
// ---------------------------------------------------------------------------
// pshb_back
// store engine: per-slice read-modify-write of ground and ceiling stores
// ---------------------------------------------------------------------------
`default_nettype none

module pshb_back #(
  parameter int GRID_ROWS  = 128,
  parameter int GRID_COLS  = 128,
  parameter int MAX_SLICES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pshb_pkg::cfg_t       cfg,
  input  pshb_pkg::cmd_t       q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 init_busy,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pshb_pkg::rsp_item_t  rsp_item
);
  import pshb_pkg::*;

  localparam int SW    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = SW + RW + CW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [2:0] {
    ST_INIT  = 3'b001,
    ST_IDLE  = 3'b010,
    ST_ISSUE = 3'b100
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic [3:0]         slice_cnt;
  logic signed [27:0] h;
  logic [AW-1:0]      sweep;

  logic               start, in_issue, issuing, act, is_last, le;
  cmd_t               cur;
  logic [3:0]         iss_slice;
  logic signed [27:0] iss_h;
  logic [AW-1:0]      raddr;

  logic               wb_valid, wb_act, wb_hit, wb_le, wb_last;
  req_kind_t          wb_op;
  logic [AW-1:0]      wb_addr;
  logic signed [23:0] wb_pz;

  logic signed [23:0] ground_mem  [DEPTH];
  logic signed [23:0] ceiling_mem [DEPTH];
  logic signed [23:0] g_rd, c_rd, g_wd, c_wd;
  logic               g_we, c_we, wb_ins, wb_clear, wb_rd;
  logic [AW-1:0]      waddr;

  // issue side
  assign in_issue  = (state == ST_ISSUE);
  assign init_busy = (state == ST_INIT);
  assign start     = (state == ST_IDLE) && !q_empty && !wb_valid
                  && (!rsp_valid || rsp_ready);
  assign issuing   = start || in_issue;
  assign q_pop     = start;
  assign cur       = in_issue ? cmd : q_head;

  always_comb begin
    if (in_issue) begin
      iss_slice = slice_cnt;
      iss_h     = h;
    end else begin
      iss_slice = (q_head.op == REQ_INSERT) ? 4'd0 : {1'b0, q_head.slice};
      iss_h     = 28'(cfg.slice_base);
    end
    act     = cur.hit && (cur.op != REQ_NONE) && !(cur.op == REQ_INSERT && cfg.ns == 4'd0);
    is_last = !(cur.op == REQ_INSERT && act) || (iss_slice == cfg.ns - 4'd1);
    le      = $signed(28'(cur.pz)) <= iss_h;
    raddr   = {SW'(iss_slice), cur.row[RW-1:0], cur.col[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      wb_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        ST_INIT: begin
          sweep <= sweep + AW'(1);
          if (&sweep) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start && !is_last) state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (is_last) state <= ST_IDLE;
        end
        default: state <= ST_INIT;
      endcase
      wb_valid <= issuing;
      if (wb_valid && wb_last) rsp_valid <= 1'b1;
      else if (rsp_ready)      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) cmd <= q_head;
    if (issuing) begin
      slice_cnt <= iss_slice + 4'd1;
      h         <= iss_h + $signed(28'(cfg.slice_step));
      wb_addr   <= raddr;
      wb_op     <= cur.op;
      wb_act    <= act;
      wb_hit    <= cur.hit;
      wb_le     <= le;
      wb_pz     <= cur.pz;
      wb_last   <= is_last;
    end
    if (wb_valid && wb_last) begin
      rsp_item.in_grid        <= wb_hit;
      rsp_item.ground_height  <= wb_rd ? g_rd : '0;
      rsp_item.ceiling_height <= wb_rd ? c_rd : '0;
    end
  end

  // write-back side
  always_comb begin
    wb_ins   = wb_valid && wb_act && (wb_op == REQ_INSERT);
    wb_clear = wb_valid && wb_act && (wb_op == REQ_CLEAR);
    wb_rd    = wb_act && (wb_op == REQ_READ || wb_op == REQ_CLEAR);
    waddr    = init_busy ? sweep : wb_addr;
    g_we     = init_busy || wb_clear || (wb_ins && wb_le && (wb_pz > g_rd));
    c_we     = init_busy || wb_clear || (wb_ins && !wb_le && (wb_pz < c_rd));
    g_wd     = wb_ins ? wb_pz : H_MIN;
    c_wd     = wb_ins ? wb_pz : H_MAX;
  end

  always_ff @(posedge clk) begin
    if (g_we) ground_mem[waddr]  <= g_wd;
    if (c_we) ceiling_mem[waddr] <= c_wd;
    g_rd <= ground_mem[raddr];
    c_rd <= ceiling_mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/point_slice_height_binning.sv
// ---------------------------------------------------------------------------
// point_slice_height_binning
// multi-slice height map builder: ground maximum and ceiling minimum per cell
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    pshb_pkg::req_item_t
//  rsp       out        rsp_valid/rsp_ready    pshb_pkg::rsp_item_t
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
//  an insert in the grid holds the store engine while it visits every slice in use in turn
//  read, clear, dropped points and undefined requests visit a single slice in the engine
//  the classifier is pipelined and runs ahead through a 4-entry queue
//  after reset both stores are swept to their sentinels, one entry a cycle, with
//  req_ready low
//  a stalled response holds the engine; the classifier keeps filling the queue
// ---------------------------------------------------------------------------
`default_nettype none

module point_slice_height_binning #(
  parameter int GRID_ROWS  = 128,
  parameter int GRID_COLS  = 128,
  parameter int MAX_SLICES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pshb_pkg::req_item_t  req_item,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pshb_pkg::rsp_item_t  rsp_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data
);
  import pshb_pkg::*;

  // configuration registers
  logic signed [23:0] center_x, center_y, slice_base;
  logic [15:0]        cell_scale;
  logic [22:0]        slice_step;
  logic [3:0]         slice_count;
  logic [7:0]         rows_used, cols_used;

  cfg_t               cfg;
  cmd_t               push_cmd, q_head;
  logic               push, q_pop, q_empty, init_busy;
  logic [CNT_W-1:0]   q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      cell_scale  <= 16'd2560;
      slice_base  <= '0;
      slice_step  <= 23'd1024;
      slice_count <= 4'd8;
      rows_used   <= 8'd128;
      cols_used   <= 8'd128;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        REG_CELL_SCALE:  cell_scale  <= cfg_data[15:0];
        REG_SLICE_BASE:  slice_base  <= cfg_data;
        REG_SLICE_STEP:  slice_step  <= cfg_data[22:0];
        REG_SLICE_COUNT: slice_count <= cfg_data[3:0];
        REG_ROWS_USED:   rows_used   <= cfg_data[7:0];
        REG_COLS_USED:   cols_used   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sizes clamp at the built grid; the clamped value is cut to the register width
  always_comb begin
    cfg.center_x   = center_x;
    cfg.center_y   = center_y;
    cfg.cell_scale = cell_scale;
    cfg.slice_base = slice_base;
    cfg.slice_step = slice_step;
    cfg.ns = (7'(slice_count) > 7'(MAX_SLICES)) ? 4'(MAX_SLICES) : slice_count;
    cfg.nr = (11'(rows_used) > 11'(GRID_ROWS)) ? 8'(GRID_ROWS) : rows_used;
    cfg.nc = (11'(cols_used) > 11'(GRID_COLS)) ? 8'(GRID_COLS) : cols_used;
  end

  // classifier: grid mapping and address checks
  pshb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .cfg       (cfg),
    .init_busy (init_busy),
    .q_count   (q_count),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decoupling queue
  pshb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  // store engine with response register
  pshb_back #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .MAX_SLICES (MAX_SLICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

endmodule

`default_nettype wire

FILE: design/pshb_checker.sv
// ---------------------------------------------------------------------------
// pshb_checker
// port-level checks on transaction ordering and response contents
// ---------------------------------------------------------------------------
`default_nettype none

module pshb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input pshb_pkg::req_item_t  req_item,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input pshb_pkg::rsp_item_t  rsp_item
);
  import pshb_pkg::*;

  logic [3:0] pend;

  // requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) pend <= '0;
    else     pend <= pend + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("response changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 4'd0)
    else $error("response without pending request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pend <= 4'd6)
    else $error("too many transactions in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.in_grid |->
      rsp_item.ground_height == '0 && rsp_item.ceiling_height == '0)
    else $error("miss response carries heights");

  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during store sweep");

endmodule

bind point_slice_height_binning pshb_checker u_chk (.*);

`default_nettype wire
